// ----- hw/rtl/one_pole_tone_shaper_unit_defines.svh -----
// ----------------------------------------------------------------------------
// One-pole tone shaper assertion macros
// Shared assertion helpers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ONE_POLE_TONE_SHAPER_UNIT_DEFINES_SVH
`define ONE_POLE_TONE_SHAPER_UNIT_DEFINES_SVH

// same-cycle implication
`define OPTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/opts_pkg.sv -----
// ----------------------------------------------------------------------------
// One-pole tone shaper package
// Widths, register codes, sequencer states and the shared multiplier control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package opts_pkg;

    // channels and sample formats
    localparam int NUM_CHANNELS = 2;
    localparam int CH_W         = 1;
    localparam int SAMPLE_W     = 24;
    localparam int ZMEM_W       = 40;
    localparam int DIFF_W       = ZMEM_W + 1;
    localparam int SHAPED_W     = ZMEM_W + 2;
    localparam int COEFF_W      = 16;
    localparam int GAIN_W       = 14;
    localparam int FRAC_EXT     = ZMEM_W - SAMPLE_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TONE_COEFF  = 2'd0,
        CFG_LINEAR_GAIN = 2'd1,
        CFG_BRIGHT_MODE = 2'd2,
        CFG_BYPASS      = 2'd3
    } cfg_idx_t;

    localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd32768;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 14'd4096;

    // shared multiplier: wide operand split in two chunks
    localparam int CHUNK_W = 21;
    localparam int MUL_A_W = CHUNK_W + 1;
    localparam int MUL_B_W = COEFF_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = DIFF_W + MUL_B_W;

    // rounding points: coefficient Q0.16, gain Q2.12 on a Q.39 value
    localparam int COEFF_SHIFT = COEFF_W;
    localparam int GAIN_SHIFT  = 28;
    localparam logic [ACC_W-1:0] ROUND_C = ACC_W'(1) << (COEFF_SHIFT - 1);
    localparam logic [ACC_W-1:0] ROUND_G = ACC_W'(1) << (GAIN_SHIFT - 1);

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // sequencer states
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DLO  = 8'b0000_0010,
        ST_DHI  = 8'b0000_0100,
        ST_UPD  = 8'b0000_1000,
        ST_SHP  = 8'b0001_0000,
        ST_SLO  = 8'b0010_0000,
        ST_SHI  = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

    // multiply-accumulate step control
    typedef struct packed {
        logic en;     // run one step
        logic hi;     // upper chunk: accumulate shifted product
        logic gain;   // gain pass: use the gain rounding bias
    } macc_ctl_t;

endpackage

// ----- hw/rtl/opts_if.sv -----
// ----------------------------------------------------------------------------
// One-pole tone shaper stream interfaces
// Valid/ready channels for the input samples and the shaped results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface opts_in_if import opts_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, channel, sample_in, input ready);
    modport sink   (input valid, channel, sample_in, output ready);
endinterface

interface opts_out_if import opts_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

// ----- hw/rtl/opts_macc.sv -----
// ----------------------------------------------------------------------------
// One-pole tone shaper multiply-accumulate
// Shared signed multiplier with a wide accumulator, one chunk per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opts_macc import opts_pkg::*;
(
    input  logic                      clk,
    input  macc_ctl_t                 ctl,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [ACC_W-1:0]   acc
);

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // the one multiplier
    assign prod     = a * b;
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    // low chunk starts with the rounding bias, high chunk adds in shifted
    always_comb
    begin
        if (ctl.hi)
        begin
            acc_next = acc_reg + (prod_ext <<< CHUNK_W);
        end
        else
        begin
            acc_next = prod_ext + (ctl.gain ? ROUND_G : ROUND_C);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- hw/rtl/one_pole_tone_shaper_unit.sv -----
// ----------------------------------------------------------------------------
// One-pole tone shaper
// Per-channel one-pole lowpass with warm/bright blend, gain and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per sample: channel (0 or 1) and a signed Q1.23
//   sample. rsp returns one beat per sample with the shaped Q1.23 result.
//   The cfg port writes tone_coeff, linear_gain, bright_mode and bypass by
//   index; write it only while no sample is in flight.
// Sequencing:
//   a filtered sample is stepped by the sequencer through one shared 22x17
//   multiplier: two chunks of the filter update, the memory update, the
//   blend, then two chunks of the gain product and the result step; a new req
//   beat is taken only once the last sample has left the result step. In
//   bypass the beat goes straight from idle to the result step.
// Reset:
//   both lowpass memories clear to zero, registers go to coefficient 0.5,
//   gain 1.0, warm mode, no bypass; no beat is pending.
// Stall:
//   the result sits in the rsp register until taken; a finished sample that
//   finds it still full waits in the last step, and req stays not ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "one_pole_tone_shaper_unit_defines.svh"

module one_pole_tone_shaper_unit import opts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    opts_in_if.sink               req,
    opts_out_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    state_t                     state_reg, state_next;
    logic [COEFF_W-1:0]         coeff_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic                       bright_reg;
    logic                       bypass_reg;

    logic [NUM_CHANNELS-1:0][ZMEM_W-1:0] z_mem_reg;

    logic [CH_W-1:0]            ch_reg;
    logic                       byp_item_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [DIFF_W-1:0]   d_reg;
    logic signed [SHAPED_W-1:0] shaped_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    logic                       accept;
    logic                       out_free;
    logic [CH_W-1:0]            ch_in;
    logic signed [ZMEM_W-1:0]   x_wide_in;
    logic signed [ZMEM_W-1:0]   z_in;
    logic signed [ZMEM_W-1:0]   z_cur;
    logic signed [ZMEM_W-1:0]   z_new;
    logic signed [SHAPED_W-1:0] x_twice;
    logic signed [ACC_W-1:0]    acc;
    macc_ctl_t                  macc_ctl;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic [ACC_W-GAIN_SHIFT-SAMPLE_W:0] y_top;
    logic signed [SAMPLE_W-1:0] y_sat;

    // handshake
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg  <= COEFF_RESET;
            gain_reg   <= GAIN_RESET;
            bright_reg <= 1'b0;
            bypass_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TONE_COEFF:  coeff_reg  <= cfg_wdata[COEFF_W-1:0];
                CFG_LINEAR_GAIN: gain_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_BRIGHT_MODE: bright_reg <= cfg_wdata[0];
                CFG_BYPASS:      bypass_reg <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bypass_reg ? ST_FIN : ST_DLO;
                end
            end
            ST_DLO:  state_next = ST_DHI;
            ST_DHI:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_SHP;
            ST_SHP:  state_next = ST_SLO;
            ST_SLO:  state_next = ST_SHI;
            ST_SHI:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // input capture and filter difference
    assign ch_in     = req.channel;
    assign x_wide_in = {req.sample_in, {FRAC_EXT{1'b0}}};
    assign z_in      = z_mem_reg[ch_in];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg       <= ch_in;
            byp_item_reg <= bypass_reg;
            x_reg        <= req.sample_in;
            d_reg        <= {x_wide_in[ZMEM_W-1], x_wide_in} - {z_in[ZMEM_W-1], z_in};
        end
    end

    // shared multiplier operands
    always_comb
    begin
        macc_ctl = '0;
        mul_a    = '0;
        mul_b    = {1'b0, coeff_reg};
        case (state_reg)
            ST_DLO:
            begin
                macc_ctl.en = 1'b1;
                mul_a       = {1'b0, d_reg[CHUNK_W-1:0]};
            end
            ST_DHI:
            begin
                macc_ctl.en = 1'b1;
                macc_ctl.hi = 1'b1;
                mul_a       = {{(MUL_A_W-(DIFF_W-CHUNK_W)){d_reg[DIFF_W-1]}},
                               d_reg[DIFF_W-1:CHUNK_W]};
            end
            ST_SLO:
            begin
                macc_ctl.en   = 1'b1;
                macc_ctl.gain = 1'b1;
                mul_a         = {1'b0, shaped_reg[CHUNK_W-1:0]};
                mul_b         = {{(MUL_B_W-GAIN_W){1'b0}}, gain_reg};
            end
            ST_SHI:
            begin
                macc_ctl.en   = 1'b1;
                macc_ctl.hi   = 1'b1;
                macc_ctl.gain = 1'b1;
                mul_a         = {{(MUL_A_W-(SHAPED_W-CHUNK_W)){shaped_reg[SHAPED_W-1]}},
                                 shaped_reg[SHAPED_W-1:CHUNK_W]};
                mul_b         = {{(MUL_B_W-GAIN_W){1'b0}}, gain_reg};
            end
            default: ;
        endcase
    end

    opts_macc u_macc
    (
        .clk (clk),
        .ctl (macc_ctl),
        .a   (mul_a),
        .b   (mul_b),
        .acc (acc)
    );

    // lowpass memory update, rounded step already in the accumulator
    assign z_cur = z_mem_reg[ch_reg];
    assign z_new = z_cur + acc[COEFF_SHIFT +: ZMEM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_mem_reg <= '0;
        end
        else if (state_reg == ST_UPD)
        begin
            z_mem_reg[ch_reg] <= z_new;
        end
    end

    // warm or bright blend
    assign x_twice = {x_reg[SAMPLE_W-1], x_reg, {(FRAC_EXT+1){1'b0}}};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SHP)
        begin
            if (bright_reg)
            begin
                shaped_reg <= x_twice - {{2{z_cur[ZMEM_W-1]}}, z_cur};
            end
            else
            begin
                shaped_reg <= {{2{z_cur[ZMEM_W-1]}}, z_cur};
            end
        end
    end

    // saturation to 24 bits
    assign y_top = acc[ACC_W-1:GAIN_SHIFT+SAMPLE_W-1];

    always_comb
    begin
        if ((y_top == '0) || (y_top == '1))
        begin
            y_sat = acc[GAIN_SHIFT +: SAMPLE_W];
        end
        else
        begin
            y_sat = acc[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FIN) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_data_reg <= byp_item_reg ? x_reg : y_sat;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.sample_out = out_data_reg;

    // checks
    `OPTS_ASSERT_NEXT(a_bypass_skips_filter, accept && bypass_reg, state_reg == ST_FIN,
        "bypass beat did not go straight to the result step")
    `OPTS_ASSERT_NEXT(a_mem_only_in_update, state_reg != ST_UPD, $stable(z_mem_reg),
        "lowpass memory changed outside the update step")
    `OPTS_ASSERT_NEXT(a_fin_waits_on_stall, (state_reg == ST_FIN) && rsp.valid && !rsp.ready,
        (state_reg == ST_FIN) && rsp.valid, "finished sample left while result was stalled")
    `OPTS_ASSERT_SAME(a_ready_only_idle, req.ready, !macc_ctl.en,
        "input ready while the multiplier is busy")

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// One-pole tone shaper testbench
// Drives sample beats on both channels with random gaps and output stalls,
// predicts every shaped sample from a cycle-free model of the filter, gain and
// saturation, and compares each result beat in order. A directed table covers
// reset state, bypass, frozen memory, saturation and register extremes, then
// random phases run under several register settings and idling profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import opts_pkg::*;

    localparam int LAT_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 6;
    localparam int PHASE_BEATS    = 90;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        cfg_idx_t                  sel;
        logic [CFG_DATA_W-1:0]     value;
        logic                      ch;
        logic signed [SAMPLE_W-1:0] sample;
        logic                      has_typed;
        logic signed [SAMPLE_W-1:0] typed_out;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    // directed table: typed result only where it is obvious
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // reset state: zero in gives zero out
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b0, 24'sd0,   1'b1, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b0, SAT_MAX,  1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b1, SAT_MIN,  1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b0, -24'sd1,  1'b0, 24'sd0},
        // bypass passes the sample and leaves memory alone
        '{ROW_WRITE,  CFG_BYPASS,      16'd1,     1'b0, 24'sd0,   1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b0, SAT_MAX,  1'b1, SAT_MAX},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b1, SAT_MIN,  1'b1, SAT_MIN},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b1, 24'sh123456, 1'b1, 24'sh123456},
        '{ROW_WRITE,  CFG_BYPASS,      16'd0,     1'b0, 24'sd0,   1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b0, 24'sd12345, 1'b0, 24'sd0},
        // zero coefficient freezes memory, bright with max gain saturates
        '{ROW_WRITE,  CFG_TONE_COEFF,  16'd0,     1'b0, 24'sd0,   1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_LINEAR_GAIN, 16'd16383, 1'b0, 24'sd0,   1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_BRIGHT_MODE, 16'd1,     1'b0, 24'sd0,   1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b1, SAT_MIN,  1'b1, SAT_MIN},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b0, SAT_MAX,  1'b1, SAT_MAX},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b0, 24'sd0,   1'b0, 24'sd0},
        // zero gain gives zero out
        '{ROW_WRITE,  CFG_LINEAR_GAIN, 16'd0,     1'b0, 24'sd0,   1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b1, SAT_MAX,  1'b1, 24'sd0},
        // largest coefficient, smallest usable gain, warm
        '{ROW_WRITE,  CFG_TONE_COEFF,  16'd65535, 1'b0, 24'sd0,   1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_LINEAR_GAIN, 16'd16,    1'b0, 24'sd0,   1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_BRIGHT_MODE, 16'd0,     1'b0, 24'sd0,   1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b0, SAT_MIN,  1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b1, SAT_MAX,  1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b1, -24'sd1,  1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b0, 24'sd1,   1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TONE_COEFF,  16'd0,     1'b1, 24'sh7F0000, 1'b0, 24'sd0}
    };

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    opts_in_if  req_ch ();
    opts_out_if rsp_ch ();

    one_pole_tone_shaper_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow registers and filter memory of the predictor
    logic [COEFF_W-1:0] coeff_reg  = COEFF_RESET;
    logic [GAIN_W-1:0]  gain_reg   = GAIN_RESET;
    bit                 bright_reg = 1'b0;
    bit                 bypass_reg = 1'b0;
    longint             lowpass_mem [NUM_CHANNELS] = '{default: 0};

    logic signed [SAMPLE_W-1:0] expected_samples [$];

    int send_idle = 20;
    int recv_idle = 72;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // filter update, bright blend, gain with rounding and saturation
    function automatic logic signed [SAMPLE_W-1:0] shape_sample(
        input logic ch, input logic signed [SAMPLE_W-1:0] x);
        longint xw;
        longint z;
        longint shaped;
        longint y;
        int     slot;
        slot = int'(ch) % NUM_CHANNELS;
        if (bypass_reg)
            return x;
        xw = longint'(x) * (longint'(1) <<< FRAC_EXT);
        z  = lowpass_mem[slot];
        z  = z + (((xw - z) * longint'(coeff_reg) + (longint'(1) <<< (COEFF_SHIFT - 1)))
                  >>> COEFF_SHIFT);
        lowpass_mem[slot] = z;
        shaped = bright_reg ? (2 * xw - z) : z;
        y = (shaped * longint'(gain_reg) + (longint'(1) <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
        if (y > longint'(SAT_MAX))
            y = longint'(SAT_MAX);
        if (y < longint'(SAT_MIN))
            y = longint'(SAT_MIN);
        return y[SAMPLE_W-1:0];
    endfunction

    // one register write, shadow follows
    task automatic set_reg(input cfg_idx_t sel, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (sel)
            CFG_TONE_COEFF:  coeff_reg  = value[COEFF_W-1:0];
            CFG_LINEAR_GAIN: gain_reg   = value[GAIN_W-1:0];
            CFG_BRIGHT_MODE: bright_reg = value[0];
            CFG_BYPASS:      bypass_reg = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // hold off input until every result is back and the pipe is empty
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    // send one sample beat, queue its expected result on acceptance
    task automatic send_sample(input logic ch, input logic signed [SAMPLE_W-1:0] x,
                               input logic has_typed,
                               input logic signed [SAMPLE_W-1:0] typed_out);
        logic signed [SAMPLE_W-1:0] predicted;
        while ($urandom_range(99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.channel   <= ch;
        req_ch.sample_in <= x;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = shape_sample(ch, x);
        expected_samples.push_back(has_typed ? typed_out : predicted);
    endtask

    // output stalls
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle);

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %0d",
                         $time, rsp_ch.sample_out);
                mismatch_count++;
            end
            else if (rsp_ch.sample_out !== expected_samples[0])
            begin
                $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                         $time, expected_samples[0], rsp_ch.sample_out);
                mismatch_count++;
                void'(expected_samples.pop_front());
            end
            else
                void'(expected_samples.pop_front());
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d results outstanding",
                         $time, expected_samples.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int                         mode;
        logic                       ch;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] held_x;
        logic [CFG_DATA_W-1:0]      coeff_val;
        logic [CFG_DATA_W-1:0]      gain_val;

        held_x = '0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_wdata        <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.channel   <= 1'b0;
        req_ch.sample_in <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_WRITE)
            begin
                settle();
                set_reg(DIRECTED[i].sel, DIRECTED[i].value);
            end
            else
                send_sample(DIRECTED[i].ch, DIRECTED[i].sample,
                            DIRECTED[i].has_typed, DIRECTED[i].typed_out);
        end

        // random phases, each with its own settings and idling profile
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            send_idle = (p < 2) ? 20 : (p < 4) ? 72 : 0;
            recv_idle = (p < 2) ? 72 : (p < 4) ? 20 : 0;
            case (p)
                0:       coeff_val = 16'd3277;
                1:       coeff_val = 16'd62259;
                4:       coeff_val = 16'($urandom_range(65535));
                default: coeff_val = 16'($urandom_range(62259, 3277));
            endcase
            case (p)
                0:       gain_val = 16'd16;
                1:       gain_val = 16'd16306;
                5:       gain_val = 16'($urandom_range(16383));
                default: gain_val = 16'($urandom_range(16306, 16));
            endcase
            set_reg(CFG_TONE_COEFF, coeff_val);
            set_reg(CFG_LINEAR_GAIN, gain_val);
            set_reg(CFG_BRIGHT_MODE, CFG_DATA_W'(p % 2));
            set_reg(CFG_BYPASS, CFG_DATA_W'(p == 3));

            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // let the output drain once in mid-stream
                if (p == 0 && n == PHASE_BEATS / 2)
                    settle();
                mode = $urandom_range(99);
                ch   = 1'($urandom_range(1));
                if (mode < 15)
                begin
                    case ($urandom_range(3))
                        0:       x = SAT_MAX;
                        1:       x = SAT_MIN;
                        2:       x = '0;
                        default: x = -24'sd1;
                    endcase
                end
                else if (mode < 35)
                    x = held_x;
                else
                    x = SAMPLE_W'($urandom);
                held_x = x;
                send_sample(ch, x, 1'b0, '0);
            end
        end

        // drain and finish
        settle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
